/* design/ictf_pkg.sv */
package ictf_pkg;
  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned AngleFracBitsDefault = 8;
  localparam int unsigned StepMax = 32;
  localparam logic [15:0] BlendGainReset = 16'd64225;
  localparam logic [19:0] SamplePeriodReset = 20'd10486;
  localparam logic [15:0] InvGain = 16'd39797;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgBlendGain = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSamplePeriod = 1'b1;

  // CORDIC vector components: 17-bit sums scaled by 2^14 plus growth headroom.
  localparam int unsigned CordW = 36;
  localparam int unsigned AngW = 28;

  function automatic logic [AngW-1:0] atan_deg_q16(input logic [4:0] i);
    logic [AngW-1:0] r;
    case (i)
      5'd0: r = 28'd2949120;
      5'd1: r = 28'd1740967;
      5'd2: r = 28'd919879;
      5'd3: r = 28'd466945;
      5'd4: r = 28'd234379;
      5'd5: r = 28'd117304;
      5'd6: r = 28'd58666;
      5'd7: r = 28'd29335;
      5'd8: r = 28'd14668;
      5'd9: r = 28'd7334;
      5'd10: r = 28'd3667;
      5'd11: r = 28'd1833;
      5'd12: r = 28'd917;
      5'd13: r = 28'd458;
      5'd14: r = 28'd229;
      5'd15: r = 28'd115;
      5'd16: r = 28'd57;
      5'd17: r = 28'd29;
      5'd18: r = 28'd14;
      5'd19: r = 28'd7;
      5'd20: r = 28'd4;
      5'd21: r = 28'd2;
      5'd22: r = 28'd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

/* design/imu_complementary_tilt_filter_unit.sv */
// Items are processed one at a time through two iterative CORDIC passes;
// the input is taken again once the result has left the output register.
// Reset is asynchronous, active low; it clears filter state and loads the
// register defaults.
module imu_complementary_tilt_filter_unit import ictf_pkg::*; #(
  parameter int unsigned CordicSteps   = CordicStepsDefault,
  parameter int unsigned AngleFracBits = AngleFracBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_ax, a_ay, a_az, b_ax, b_ay, b_az, a_rx, a_ry, b_rx, b_ry (16 bit each)
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pitch_angle [23:0], yaw_angle [47:24]
  output logic [47:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [19:0]  cfg_data_i
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StYaw   = 7'b0000010,
    StMag   = 7'b0000100,
    StPitch = 7'b0001000,
    StMul   = 7'b0010000,
    StFilt  = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  localparam int unsigned Cs = 16 - AngleFracBits;
  localparam int unsigned Gs = 25 - AngleFracBits;

  state_e st_q, st_d;
  logic [15:0] alpha_q;
  logic [19:0] dt_q;
  logic signed [31:0] lp_p_q, lp_y_q, hp_p_q, hp_y_q;
  logic signed [16:0] ax_q, ay_q, az_q, rx_q, ry_q;
  logic signed [AngW-1:0] yaw_q, pitch_q;
  logic signed [CordW-1:0] mag_q;
  logic [47:0] out_q;
  logic ovalid_q;
  logic [1:0] sub_q;
  logic signed [63:0] m1_q, m2_q;

  logic cstart, cdone;
  logic signed [CordW-1:0] cx, cy, cmag;
  logic signed [AngW-1:0] cang;

  function automatic logic signed [15:0] fld(input logic [159:0] d, input int k);
    return d[k*16 +: 16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [23:0] sat24(input logic signed [32:0] v);
    if (v > 33'sd8388607) return 24'h7fffff;
    if (v < -33'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  assign cx = (st_q == StYaw) ? CordW'(az_q) <<< 14 : mag_q;
  assign cy = (st_q == StYaw) ? CordW'(ay_q) <<< 14 : -(CordW'(ax_q) <<< 14);

  ictf_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .x_i(cx), .y_i(cy),
    .done_o(cdone), .ang_o(cang), .mag_o(cmag)
  );

  assign s_axis_tready = (st_q == StIdle) && !ovalid_q;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = out_q;
  // The yaw pass starts in StYaw once sub_q has advanced to 1; the pitch pass likewise in StMag.
  assign cstart = (st_q == StYaw && sub_q == 2'd1) || (st_q == StMag && sub_q == 2'd1);

  logic signed [63:0] pang, yang;
  assign pang = rnd(64'(pitch_q), Cs);
  assign yang = rnd(64'(yaw_q), Cs);

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (s_axis_tvalid && s_axis_tready) st_d = StYaw;
      StYaw:   if (cdone) st_d = StMag;
      StMag:   if (cdone) st_d = StMul;
      StMul:   if (sub_q == 2'd3) st_d = StFilt;
      StFilt:  if (sub_q == 2'd1) st_d = StOut;
      StOut:   st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; sub_q <= '0; ovalid_q <= 1'b0;
      alpha_q <= BlendGainReset; dt_q <= SamplePeriodReset;
      lp_p_q <= '0; lp_y_q <= '0; hp_p_q <= '0; hp_y_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgBlendGain:    alpha_q <= cfg_data_i[15:0];
          CfgSamplePeriod: dt_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      sub_q <= (st_d != st_q) ? 2'd0 : ((sub_q == 2'd3) ? sub_q : sub_q + 2'd1);
      case (st_q)
        StMul: begin
          case (sub_q)
            2'd1: begin
              lp_p_q <= sat32(64'(lp_p_q) + rnd(m1_q, 16));
              lp_y_q <= sat32(64'(lp_y_q) + rnd(m2_q, 16));
            end
            default: ;
          endcase
        end
        StFilt: begin
          case (sub_q)
            2'd0: begin
              hp_p_q <= sat32(rnd(m1_q, 16));
              hp_y_q <= sat32(rnd(m2_q, 16));
            end
            default: ;
          endcase
        end
        StOut: begin
          out_q <= {sat24(33'(lp_y_q) + 33'(hp_y_q)), sat24(33'(lp_p_q) + 33'(hp_p_q))};
          ovalid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Products: each multiplier has one operand of at most 17 bits and is registered.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ax_q <= 17'(fld(s_axis_tdata, 0)) + 17'(fld(s_axis_tdata, 3));
      ay_q <= 17'(fld(s_axis_tdata, 1)) + 17'(fld(s_axis_tdata, 4));
      az_q <= 17'(fld(s_axis_tdata, 2)) + 17'(fld(s_axis_tdata, 5));
      rx_q <= 17'(fld(s_axis_tdata, 6)) + 17'(fld(s_axis_tdata, 8));
      ry_q <= 17'(fld(s_axis_tdata, 7)) + 17'(fld(s_axis_tdata, 9));
    end
    if (st_q == StYaw && cdone) begin
      yaw_q <= cang;
      mag_q <= CordW'((64'($unsigned(cmag)) * 64'(InvGain)) >> 16);
    end
    if (st_q == StMag && cdone) pitch_q <= cang;
    if (st_q == StMag && cdone) begin
      m1_q <= '0; m2_q <= '0;
    end
    case (st_q)
      StMul: begin
        case (sub_q)
          2'd0: ;
          2'd1: ;
          2'd2: begin
            m1_q <= 64'(rx_q) * 64'($signed({1'b0, dt_q}));
            m2_q <= 64'(ry_q) * 64'($signed({1'b0, dt_q}));
          end
          2'd3: begin
            m1_q <= 64'($signed({1'b0, alpha_q})) * (64'(hp_p_q) + rnd(m1_q, Gs));
            m2_q <= 64'($signed({1'b0, alpha_q})) * (64'(hp_y_q) + rnd(m2_q, Gs));
          end
          default: ;
        endcase
        if (sub_q == 2'd0) begin
          m1_q <= (64'sd65536 - 64'(alpha_q)) * (pang - 64'(lp_p_q));
          m2_q <= (64'sd65536 - 64'(alpha_q)) * (yang - 64'(lp_y_q));
        end
      end
      default: ;
    endcase
  end
endmodule

/* design/ictf_cordic.sv */
module ictf_cordic import ictf_pkg::*; #(
  parameter int unsigned CordicSteps = CordicStepsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CordW-1:0]  x_i,
  input  logic signed [CordW-1:0]  y_i,
  output logic                     done_o,
  output logic signed [AngW-1:0]   ang_o,
  output logic signed [CordW-1:0]  mag_o
);
  localparam int unsigned Steps = (CordicSteps > StepMax) ? StepMax : CordicSteps;

  logic signed [CordW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AngW-1:0] z_q, z_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic signed [CordW-1:0] xs, ys;

  // One micro-rotation per cycle through a barrel shift of the step count.
  assign xs = x_q >>> cnt_q[4:0];
  assign ys = y_q >>> cnt_q[4:0];

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      cnt_d = '0;
      if (x_i == '0 && y_i == '0) begin
        x_d = '0; y_d = '0; z_d = '0; busy_d = 1'b0; done_d = 1'b1;
      end else if (x_i < 0) begin
        x_d = -x_i; y_d = -y_i;
        z_d = (y_i >= 0) ? AngW'(180 * 65536) : -AngW'(180 * 65536);
        busy_d = 1'b1;
      end else begin
        x_d = x_i; y_d = y_i; z_d = '0; busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + $signed(atan_deg_q16(cnt_q[4:0]));
      end else begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - $signed(atan_deg_q16(cnt_q[4:0]));
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(Steps - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign done_o = done_q;
  assign ang_o = z_q;
  assign mag_o = x_q;
endmodule

/* design/ictf_checker.sv */
module ictf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input open while result pending");
endmodule

bind imu_complementary_tilt_filter_unit ictf_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

/* bench/ictf_tilt_checker.sv */
`timescale 1ns / 100ps

module ictf_tilt_checker import ictf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic               s_ready_i,
  input  logic [159:0]       s_data_i,
  input  logic               m_valid_i,
  input  logic               m_ready_i,
  input  logic [47:0]        m_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 angles_pending_o
);

  typedef struct packed {
    logic signed [23:0] yaw;
    logic signed [23:0] pitch;
  } tilt_t;

  localparam longint AtanDegQ16 [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic [15:0] alpha_q;
  logic [19:0] dt_q;
  longint      pitch_lp, yaw_lp, pitch_hp, yaw_hp;
  tilt_t       tilt_q[$];
  int          fail_count;

  assign fail_count_o     = fail_count;
  assign angles_pending_o = tilt_q.size();

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Vectoring CORDIC; returns degrees Q.16 and the gain-scaled magnitude.
  function automatic longint vector_angle(longint y, longint x, output longint mag);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += AtanDegQ16[i];
      end else begin
        x -= ys; y += xs; z -= AtanDegQ16[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint field(logic [159:0] d, int k);
    return longint'($signed(d[16*k +: 16]));
  endfunction

  function automatic tilt_t fuse_sample(logic [159:0] d);
    longint ax, ay, az, rx, ry, mag, mag_n, dummy, yaw_a, pitch_a, inc, g;
    tilt_t   r;
    ax = field(d, 0) + field(d, 3);
    ay = field(d, 1) + field(d, 4);
    az = field(d, 2) + field(d, 5);
    rx = field(d, 6) + field(d, 8);
    ry = field(d, 7) + field(d, 9);
    yaw_a   = vector_angle(ay * 16384, az * 16384, mag);
    mag_n   = (mag * 39797) >> 16;
    pitch_a = vector_angle(-ax * 16384, mag_n, dummy);
    yaw_a   = round_shift(yaw_a, 8);
    pitch_a = round_shift(pitch_a, 8);
    g = 65536 - longint'(alpha_q);
    pitch_lp = clamp(pitch_lp + round_shift(g * (pitch_a - pitch_lp), 16), 32);
    yaw_lp   = clamp(yaw_lp + round_shift(g * (yaw_a - yaw_lp), 16), 32);
    inc = round_shift(rx * longint'(dt_q), 17);
    pitch_hp = clamp(round_shift(longint'(alpha_q) * (pitch_hp + inc), 16), 32);
    inc = round_shift(ry * longint'(dt_q), 17);
    yaw_hp = clamp(round_shift(longint'(alpha_q) * (yaw_hp + inc), 16), 32);
    r.pitch = 24'(clamp(pitch_lp + pitch_hp, 24));
    r.yaw   = 24'(clamp(yaw_lp + yaw_hp, 24));
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    tilt_t got, want;
    if (!rst_ni) begin
      alpha_q    <= BlendGainReset;
      dt_q       <= SamplePeriodReset;
      pitch_lp   = 0;
      yaw_lp     = 0;
      pitch_hp   = 0;
      yaw_hp     = 0;
      fail_count <= 0;
      tilt_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgBlendGain) alpha_q <= cfg_data_i[15:0];
        else if (cfg_index_i == CfgSamplePeriod) dt_q <= cfg_data_i;
      end
      if (s_valid_i && s_ready_i) tilt_q.push_back(fuse_sample(s_data_i));
      if (m_valid_i && m_ready_i) begin
        got = m_data_i;
        if (tilt_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result item %h", m_data_i);
        end else begin
          want = tilt_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: pitch exp %0d got %0d, yaw exp %0d got %0d",
                       want.pitch, got.pitch, want.yaw, got.yaw);
          end
        end
      end
    end
  end

endmodule

/* bench/tb_imu_complementary_tilt_filter_unit.sv */
`timescale 1ns / 100ps

module tb_imu_complementary_tilt_filter_unit;
  import ictf_pkg::*;

  localparam int Stall = 2000;

  logic               clk_i, rst_ni;
  logic               s_axis_tvalid, s_axis_tready;
  logic [159:0]       s_axis_tdata;
  logic               m_axis_tvalid, m_axis_tready;
  logic [47:0]        m_axis_tdata;
  logic               cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [19:0]        cfg_data_i;
  int                 fail_count, angles_pending;
  int                 quiet_cycles;
  bit                 no_idle, hold_req, hold_done;

  imu_complementary_tilt_filter_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  ictf_tilt_checker i_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .angles_pending_o(angles_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= Stall) begin
      $display("imu_complementary_tilt_filter_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: random stalls, one long hold-off on request.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic logic [159:0] pack_sample(logic [15:0] ax, ay, az, bx, by, bz,
                                               rax, ray, rbx, rby);
    return {rby, rbx, ray, rax, bz, by, bx, az, ay, ax};
  endfunction

  task automatic send_sample(logic [159:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [19:0] val);
    s_axis_tvalid <= 1'b0;
    // The edge wait lets the checker record the last accepted item first.
    @(posedge clk_i);
    wait (angles_pending == 0);
    repeat (60) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] accel_value();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 64)) - 32);
      1: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_samples(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_sample(pack_sample(accel_value(), accel_value(), accel_value(),
                              accel_value(), accel_value(), accel_value(),
                              16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom)));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    logic [15:0] mx, mn;
    mx = 16'h7fff;
    mn = 16'h8000;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgBlendGain;
    cfg_data_i = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items: extremes, zero vector, negative-axis turns.
    send_sample(pack_sample(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_sample(pack_sample(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send_sample('0);
    send_sample(pack_sample(mx, 0, 0, mx, 0, 0, 0, 0, 0, 0));
    send_sample(pack_sample(mn, 0, 0, mn, 0, 0, 0, 0, 0, 0));
    send_sample(pack_sample(0, 0, mn, 0, 0, mn, 0, 0, 0, 0));
    send_sample(pack_sample(0, 16'hffff, mn, 0, 0, mn, 0, 0, 0, 0));
    send_sample(pack_sample(0, 1, 16'hffff, 0, 0, 0, 0, 0, 0, 0));
    send_sample(pack_sample(0, mx, 0, 0, mx, 0, mx, mn, mx, mn));
    send_sample(pack_sample(0, mn, 0, 0, mn, 0, mn, mx, mn, mx));
    send_sample(pack_sample(mx, mn, mx, mn, mx, mn, 1, 16'hffff, 0, 0));
    random_samples(300);

    write_reg(CfgBlendGain, 20'd0);
    write_reg(CfgSamplePeriod, 20'hfffff);
    random_samples(300);

    write_reg(CfgBlendGain, 20'd65535);
    write_reg(CfgSamplePeriod, 20'd0);
    random_samples(250);

    write_reg(CfgSamplePeriod, 20'd1);
    random_samples(250);

    write_reg(CfgBlendGain, 20'd32768);
    write_reg(CfgSamplePeriod, 20'd10486);
    hold_req = 1'b1;
    random_samples(300);

    write_reg(CfgBlendGain, 20'($urandom_range(0, 65535)));
    write_reg(CfgSamplePeriod, 20'($urandom_range(1, 1048575)));
    random_samples(300);

    write_reg(CfgBlendGain, 20'd65535);
    write_reg(CfgSamplePeriod, 20'hfffff);
    random_samples(300);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (angles_pending == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && angles_pending == 0) begin
      $display("imu_complementary_tilt_filter_unit regression: pass");
    end else begin
      $display("imu_complementary_tilt_filter_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ictf_pkg.sv
design/ictf_cordic.sv
design/imu_complementary_tilt_filter_unit.sv
design/ictf_checker.sv
bench/ictf_tilt_checker.sv
bench/tb_imu_complementary_tilt_filter_unit.sv
